[rtl/fcmq_pkg.sv]
// Shared types and constants for the int8 fully connected MAC and requantize block.
package fcmq_pkg;

    // Field and register widths
    localparam int ByteW   = 8;
    localparam int ZeroW   = 9;
    localparam int OpW     = 10;
    localparam int ProdW   = 2 * OpW;
    localparam int AccW    = 32;
    localparam int ShiftW  = 6;
    localparam int CfgIdxW = 3;
    localparam int CfgDatW = 9;

    // Configuration register indexes
    localparam logic [CfgIdxW-1:0] CfgInZero   = 3'd0;
    localparam logic [CfgIdxW-1:0] CfgWtZero   = 3'd1;
    localparam logic [CfgIdxW-1:0] CfgResOfs   = 3'd2;
    localparam logic [CfgIdxW-1:0] CfgClampLow = 3'd3;
    localparam logic [CfgIdxW-1:0] CfgClampHi  = 3'd4;

    // Register reset values
    localparam logic signed [ByteW-1:0] ClampLowRst = -8'sd128;
    localparam logic signed [ByteW-1:0] ClampHiRst  = 8'sd127;

    // Rounding constant for the Q31 scale, 2^30
    localparam logic signed [2*AccW-1:0] RoundQ31 = 64'sh0000_0000_4000_0000;

    // Controller to datapath commands
    typedef struct packed {
        logic acc_en;   // accumulate the accepted beat
        logic last;     // accepted beat closes the dot product
        logic bias_en;  // add bias to the captured sum
        logic mul_en;   // multiply by the channel multiplier
        logic rnd_en;   // Q31 round and narrow
        logic shf_en;   // per-channel shift
        logic out_load; // offset, clamp and load output byte
    } t_dp_cmd;

endpackage

[rtl/int8_fc_mac_requantize.sv]
// A term that is not last is accumulated at the edge that accepts it.
// A last term starts a requantize sequence (bias, multiply, round, shift, clamp);
// its byte is loaded in the clamp state, which waits while the output stalls.
// Throughput: 1 term per cycle; a last term stalls the input until its byte loads.
// Reset (synchronous, active low) clears the accumulator, the output valid flag
// and the config registers (offsets 0, clamp range -128 to 127).
module int8_fc_mac_requantize (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [fcmq_pkg::CfgIdxW-1:0]        i_cfg_index,
    input  logic [fcmq_pkg::CfgDatW-1:0]        i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic signed [fcmq_pkg::ByteW-1:0]   i_in_value,
    input  logic signed [fcmq_pkg::ByteW-1:0]   i_weight_value,
    input  logic signed [fcmq_pkg::AccW-1:0]    i_bias_value,
    input  logic signed [fcmq_pkg::AccW-1:0]    i_channel_multiplier,
    input  logic signed [fcmq_pkg::ShiftW-1:0]  i_channel_shift,
    input  logic                                i_last_term,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic signed [fcmq_pkg::ByteW-1:0]   o_out_value
);

    fcmq_pkg::t_dp_cmd cmd;

    fcmq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_last_term (i_last_term),
        .o_in_stall  (o_in_stall),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_cmd       (cmd)
    );

    fcmq_dpath u_dpath (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cfg_we             (i_cfg_we),
        .i_cfg_index          (i_cfg_index),
        .i_cfg_data           (i_cfg_data),
        .i_in_value           (i_in_value),
        .i_weight_value       (i_weight_value),
        .i_bias_value         (i_bias_value),
        .i_channel_multiplier (i_channel_multiplier),
        .i_channel_shift      (i_channel_shift),
        .i_cmd                (cmd),
        .o_out_value          (o_out_value)
    );

endmodule

[rtl/fcmq_ctrl.sv]
// Controller: sequences the requantize steps and owns the handshakes.
module fcmq_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_last_term,
    output logic                 o_in_stall,
    input  logic                 i_out_stall,
    output logic                 o_out_valid,
    output fcmq_pkg::t_dp_cmd    o_cmd
);

    localparam logic [2:0] StIdle = 3'd0;
    localparam logic [2:0] StBias = 3'd1;
    localparam logic [2:0] StMul  = 3'd2;
    localparam logic [2:0] StRnd  = 3'd3;
    localparam logic [2:0] StShf  = 3'd4;
    localparam logic [2:0] StClp  = 3'd5;

    logic [2:0] r_state, n_state;
    logic       r_out_valid, n_out_valid;
    logic       in_beat;
    logic       out_free;

    assign o_in_stall = (r_state != StIdle);
    assign in_beat    = i_in_valid && !o_in_stall;
    assign out_free   = !r_out_valid || !i_out_stall;
    assign o_out_valid = r_out_valid;

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            StIdle: begin
                o_cmd.acc_en = in_beat;
                o_cmd.last   = in_beat && i_last_term;
                if (in_beat && i_last_term) begin
                    n_state = StBias;
                end
            end
            StBias: begin
                o_cmd.bias_en = 1'b1;
                n_state = StMul;
            end
            StMul: begin
                o_cmd.mul_en = 1'b1;
                n_state = StRnd;
            end
            StRnd: begin
                o_cmd.rnd_en = 1'b1;
                n_state = StShf;
            end
            StShf: begin
                o_cmd.shf_en = 1'b1;
                n_state = StClp;
            end
            StClp: begin
                // wait here until the output register can take the byte
                o_cmd.out_load = out_free;
                if (out_free) begin
                    n_state = StIdle;
                end
            end
            default: begin
                n_state = StIdle;
            end
        endcase
    end

    // Output valid flag
    always_comb begin
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= StIdle;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

[rtl/fcmq_dpath.sv]
// Datapath: MAC accumulator, config registers and requantize pipeline registers.
module fcmq_dpath (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_cfg_we,
    input  logic [fcmq_pkg::CfgIdxW-1:0]            i_cfg_index,
    input  logic [fcmq_pkg::CfgDatW-1:0]            i_cfg_data,
    input  logic signed [fcmq_pkg::ByteW-1:0]       i_in_value,
    input  logic signed [fcmq_pkg::ByteW-1:0]       i_weight_value,
    input  logic signed [fcmq_pkg::AccW-1:0]        i_bias_value,
    input  logic signed [fcmq_pkg::AccW-1:0]        i_channel_multiplier,
    input  logic signed [fcmq_pkg::ShiftW-1:0]      i_channel_shift,
    input  fcmq_pkg::t_dp_cmd                       i_cmd,
    output logic signed [fcmq_pkg::ByteW-1:0]       o_out_value
);

    // Config registers
    logic signed [fcmq_pkg::ZeroW-1:0] r_in_zero, r_wt_zero;
    logic signed [fcmq_pkg::ByteW-1:0] r_res_ofs, r_clamp_low, r_clamp_hi;

    // Accumulator and captured channel data
    logic [fcmq_pkg::AccW-1:0]               r_acc, r_sum;
    logic [fcmq_pkg::AccW-1:0]               r_bias;
    logic signed [fcmq_pkg::AccW-1:0]        r_mult;
    logic signed [fcmq_pkg::ShiftW-1:0]      r_shift;
    logic signed [2*fcmq_pkg::AccW-1:0]      r_prod;
    logic signed [fcmq_pkg::AccW-1:0]        r_scaled;
    logic signed [fcmq_pkg::AccW:0]          r_shifted;
    logic signed [fcmq_pkg::ByteW-1:0]       r_out;

    logic signed [fcmq_pkg::OpW-1:0]         x_op, w_op;
    logic signed [fcmq_pkg::ProdW-1:0]       term;
    logic [fcmq_pkg::AccW-1:0]               acc_sum;
    logic signed [2*fcmq_pkg::AccW-1:0]      prod_rnd;
    logic [4:0]                              rsh_amt;
    logic [fcmq_pkg::ShiftW-1:0]             lsh_amt;
    logic signed [fcmq_pkg::AccW:0]          rsh_in;
    logic signed [fcmq_pkg::AccW:0]          rsh_half;
    logic [fcmq_pkg::AccW-1:0]               lsh_out;
    logic signed [fcmq_pkg::AccW:0]          shf_val;
    logic signed [fcmq_pkg::AccW+1:0]        ofs_val;
    logic signed [fcmq_pkg::AccW+1:0]        clp_val;

    // Config writes; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_zero   <= '0;
            r_wt_zero   <= '0;
            r_res_ofs   <= '0;
            r_clamp_low <= fcmq_pkg::ClampLowRst;
            r_clamp_hi  <= fcmq_pkg::ClampHiRst;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                fcmq_pkg::CfgInZero:   r_in_zero   <= i_cfg_data;
                fcmq_pkg::CfgWtZero:   r_wt_zero   <= i_cfg_data;
                fcmq_pkg::CfgResOfs:   r_res_ofs   <= i_cfg_data[fcmq_pkg::ByteW-1:0];
                fcmq_pkg::CfgClampLow: r_clamp_low <= i_cfg_data[fcmq_pkg::ByteW-1:0];
                fcmq_pkg::CfgClampHi:  r_clamp_hi  <= i_cfg_data[fcmq_pkg::ByteW-1:0];
                default: begin
                end
            endcase
        end
    end

    // Offset operands and one product term
    assign x_op    = fcmq_pkg::OpW'(i_in_value) + fcmq_pkg::OpW'(r_in_zero);
    assign w_op    = fcmq_pkg::OpW'(i_weight_value) + fcmq_pkg::OpW'(r_wt_zero);
    assign term    = x_op * w_op;
    assign acc_sum = r_acc + fcmq_pkg::AccW'(term);

    // Accumulator, cleared once the last term is captured
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
        end else if (i_cmd.acc_en) begin
            r_acc <= i_cmd.last ? '0 : acc_sum;
        end
    end

    // Capture the closing sum and channel parameters, then add bias
    always_ff @(posedge i_clk) begin
        if (i_cmd.last) begin
            r_sum   <= acc_sum;
            r_bias  <= i_bias_value;
            r_mult  <= i_channel_multiplier;
            r_shift <= i_channel_shift;
        end else if (i_cmd.bias_en) begin
            r_sum   <= r_sum + r_bias;
        end
    end

    // Q31 multiply, registered before rounding
    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_en) begin
            r_prod <= $signed(r_sum) * r_mult;
        end
    end

    // Round to nearest, floor shift by 31, keep low 32 bits
    assign prod_rnd = r_prod + fcmq_pkg::RoundQ31;

    always_ff @(posedge i_clk) begin
        if (i_cmd.rnd_en) begin
            r_scaled <= prod_rnd[62:31];
        end
    end

    // Per-channel shift: right with round-half-up, left with 32-bit wrap
    assign rsh_amt  = r_shift[4:0];
    assign lsh_amt  = fcmq_pkg::ShiftW'(-r_shift);
    assign rsh_half = (fcmq_pkg::AccW+1)'(1) << (rsh_amt - 5'd1);
    assign rsh_in   = (fcmq_pkg::AccW+1)'(r_scaled) + rsh_half;
    assign lsh_out  = lsh_amt[5] ? '0 : (r_scaled << lsh_amt[4:0]);

    always_comb begin
        if (r_shift > 0) begin
            shf_val = rsh_in >>> rsh_amt;
        end else if (r_shift < 0) begin
            shf_val = (fcmq_pkg::AccW+1)'($signed(lsh_out));
        end else begin
            shf_val = (fcmq_pkg::AccW+1)'(r_scaled);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.shf_en) begin
            r_shifted <= shf_val;
        end
    end

    // Result offset, then low clamp, then high clamp
    assign ofs_val = (fcmq_pkg::AccW+2)'(r_shifted) + (fcmq_pkg::AccW+2)'(r_res_ofs);

    always_comb begin
        clp_val = ofs_val;
        if (clp_val < (fcmq_pkg::AccW+2)'(r_clamp_low)) begin
            clp_val = (fcmq_pkg::AccW+2)'(r_clamp_low);
        end
        if (clp_val > (fcmq_pkg::AccW+2)'(r_clamp_hi)) begin
            clp_val = (fcmq_pkg::AccW+2)'(r_clamp_hi);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out <= clp_val[fcmq_pkg::ByteW-1:0];
        end
    end

    assign o_out_value = r_out;

endmodule

[rtl/fcmq_check.sv]
// Port-level checker for the MAC and requantize block, bound to the top level.
module fcmq_check (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    input  logic                                o_in_stall,
    input  logic                                i_last_term,
    input  logic                                o_out_valid,
    input  logic                                i_out_stall,
    input  logic signed [fcmq_pkg::ByteW-1:0]   o_out_value
);

    logic in_beat;
    assign in_beat = i_in_valid && !o_in_stall;

    // A stalled output beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_value))
        else $error("output beat changed while stalled");

    // A last term blocks the input while it is requantized
    a_last_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_beat && i_last_term |=> o_in_stall)
        else $error("input not stalled after last term");

    // A term that is not last produces no result
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_beat && !i_last_term |=> !$rose(o_out_valid))
        else $error("result appeared after a term that was not last");

    // A new result coincides with the input reopening
    a_result_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $fell(o_in_stall))
        else $error("result without end of requantize sequence");

endmodule

bind int8_fc_mac_requantize fcmq_check u_fcmq_check (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_last_term (i_last_term),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_value (o_out_value)
);
